### sv/miller_rabin_primality_test_macros.svh
// Assertion macros shared by the primality tester.
`ifndef MILLER_RABIN_PRIMALITY_TEST_MACROS_SVH
`define MILLER_RABIN_PRIMALITY_TEST_MACROS_SVH

// Implication that must hold on every clock edge outside reset.
`define MRPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define MRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/mrpt_pkg.sv
package mrpt_pkg;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [0:0] REG_ROUNDS = 1'b0;
    localparam logic [0:0] REG_SEED   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT,
        S_TRIAL,
        S_WRED,
        S_POW,
        S_MUL,
        S_MUL_RED,
        S_CHECK,
        S_SQUARE,
        S_SQ_RED,
        S_SQ_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_red_ctl;

endpackage

### sv/mrpt_modred.sv
module mrpt_modred #(
    parameter int W  = 32,
    parameter int VW = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [VW-1:0]  i_value,
    input  logic [W-1:0]   i_modulus,
    output mrpt_pkg::t_red_ctl o_ctl,
    output logic [W-1:0]   o_rem
);
    localparam int CW = $clog2(VW + 1);

    logic [W:0]     r_rem;
    logic [VW-1:0]  r_val;
    logic [W-1:0]   r_mod;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W:0]     n_shift;
    logic [W:0]     n_diff;

    assign n_shift = {r_rem[W-1:0], r_val[VW-1]};
    assign n_diff  = n_shift - {1'b0, r_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_val  <= i_value;
                r_mod  <= i_modulus;
                r_cnt  <= CW'(VW);
            end else if (r_busy) begin
                r_rem <= n_diff[W] ? n_shift : n_diff;
                r_val <= {r_val[VW-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_rem       = r_rem[W-1:0];
endmodule

### sv/miller_rabin_primality_test.sv
// Miller-Rabin probable-prime tester. Pulse i_start with i_candidate while
// o_busy is low; one result appears on o_probably_prime with o_valid high for
// exactly one cycle and cannot be stalled, so the receiver must always take it.
// Every modular product runs through one shared bit-serial reducer over VW-bit
// values (VW = 2W, at least 32). A trial reduces a witness, runs square-and-
// multiply over each bit of d and then squares the result; the default four
// rounds end early on the first composite proof. Candidates 0 to 4 are
// answered from the split step without any trial.
`include "miller_rabin_primality_test_macros.svh"

module miller_rabin_primality_test #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_candidate,
    output logic        o_busy,
    output logic        o_valid,
    output logic        o_probably_prime,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int W  = NUMBER_WIDTH;
    localparam int VW = (2 * W > 32) ? 2 * W : 32;
    localparam int SW = $clog2(W + 1);

    mrpt_pkg::t_state r_state, n_state;
    mrpt_pkg::t_red_ctl red_ctl;

    logic [6:0]   r_rounds;
    logic [31:0]  r_lfsr;
    logic [W-1:0] r_n, r_d, r_e, r_base, r_acc, r_x;
    logic [SW-1:0] r_s, r_i;
    logic [6:0]   r_trial;
    logic         r_prime;
    logic         r_valid;
    logic         red_start;
    logic [VW-1:0] red_value;
    logic [W-1:0] red_mod, red_rem;
    logic [31:0]  lfsr_next;
    logic [W-1:0] cand, nm1;
    logic         r_mul_phase;

    assign cand = i_candidate[W-1:0];
    assign nm1  = r_n - W'(1);
    assign lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ mrpt_pkg::LFSR_TAPS) : (r_lfsr >> 1);
    assign o_cfg_ready = (r_state == mrpt_pkg::S_IDLE) && !i_start;

    mrpt_modred #(.W(W), .VW(VW)) u_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(red_start),
        .i_value(red_value), .i_modulus(red_mod), .o_ctl(red_ctl), .o_rem(red_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mrpt_pkg::S_IDLE;
            r_rounds <= 7'd4;
            r_lfsr   <= 32'd1;
            r_valid  <= 1'b0;
            r_prime  <= 1'b0;
            r_mul_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == mrpt_pkg::REG_ROUNDS) begin
                    r_rounds <= i_cfg_data[6:0];
                end else begin
                    r_lfsr <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                end
            end
            unique case (r_state)
                mrpt_pkg::S_IDLE: begin
                    if (i_start) begin
                        r_n <= cand;
                        r_d <= cand - W'(1);
                        r_s <= '0;
                        r_trial <= '0;
                        r_prime <= 1'b1;
                    end
                end
                mrpt_pkg::S_SPLIT: begin
                    if (r_n <= W'(1) || r_n == W'(4)) begin
                        r_prime <= 1'b0;
                    end else if (!r_d[0] && r_n > W'(3)) begin
                        r_d <= r_d >> 1;
                        r_s <= r_s + SW'(1);
                    end
                end
                mrpt_pkg::S_TRIAL: begin
                    if (r_trial != r_rounds) begin
                        r_lfsr  <= lfsr_next;
                        r_trial <= r_trial + 7'd1;
                    end
                end
                mrpt_pkg::S_WRED: begin
                    if (red_ctl.done) begin
                        r_base <= red_rem + W'(2);
                        r_acc  <= W'(1);
                        r_e    <= r_d;
                    end
                end
                mrpt_pkg::S_POW: r_mul_phase <= 1'b0;
                mrpt_pkg::S_MUL_RED: begin
                    if (red_ctl.done) begin
                        if (!r_mul_phase) begin
                            r_acc <= red_rem;
                            r_mul_phase <= 1'b1;
                        end else begin
                            r_base <= red_rem;
                            r_e <= r_e >> 1;
                            r_mul_phase <= 1'b0;
                        end
                    end
                end
                mrpt_pkg::S_CHECK: begin
                    r_x <= r_acc;
                    r_i <= SW'(1);
                    if (!(r_acc == W'(1) || r_acc == nm1) && r_s <= SW'(1)) begin
                        r_prime <= 1'b0;
                    end
                end
                mrpt_pkg::S_SQ_RED: begin
                    if (red_ctl.done) begin
                        r_x <= red_rem;
                    end
                end
                mrpt_pkg::S_SQ_CHECK: begin
                    r_i <= r_i + SW'(1);
                    if (r_x == W'(1)) begin
                        r_prime <= 1'b0;
                    end else if (r_x != nm1 && r_i + SW'(1) >= r_s) begin
                        r_prime <= 1'b0;
                    end
                end
                mrpt_pkg::S_DONE: r_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        red_start = 1'b0;
        red_value = '0;
        red_mod   = r_n;
        unique case (r_state)
            mrpt_pkg::S_IDLE: if (i_start) n_state = mrpt_pkg::S_SPLIT;
            mrpt_pkg::S_SPLIT: begin
                if (r_n <= W'(4)) begin
                    n_state = mrpt_pkg::S_DONE;
                end else if (r_d[0]) begin
                    n_state = mrpt_pkg::S_TRIAL;
                end
            end
            mrpt_pkg::S_TRIAL: begin
                if (r_trial == r_rounds || !r_prime) begin
                    n_state = mrpt_pkg::S_DONE;
                end else begin
                    red_start = 1'b1;
                    red_value = VW'(lfsr_next);
                    red_mod   = r_n - W'(4);
                    n_state   = mrpt_pkg::S_WRED;
                end
            end
            mrpt_pkg::S_WRED: begin
                red_mod = r_n - W'(4);
                if (red_ctl.done) n_state = mrpt_pkg::S_POW;
            end
            mrpt_pkg::S_POW: begin
                n_state = (r_e == '0) ? mrpt_pkg::S_CHECK : mrpt_pkg::S_MUL;
            end
            mrpt_pkg::S_MUL: begin
                red_start = 1'b1;
                if (!r_mul_phase) begin
                    red_value = r_e[0] ? r_acc * r_base : VW'(r_acc);
                end else begin
                    red_value = r_base * r_base;
                end
                n_state = mrpt_pkg::S_MUL_RED;
            end
            mrpt_pkg::S_MUL_RED: begin
                if (red_ctl.done) begin
                    n_state = r_mul_phase ? mrpt_pkg::S_POW : mrpt_pkg::S_MUL;
                end
            end
            mrpt_pkg::S_CHECK: begin
                if (r_acc == W'(1) || r_acc == nm1) begin
                    n_state = mrpt_pkg::S_TRIAL;
                end else if (r_s <= SW'(1)) begin
                    n_state = mrpt_pkg::S_DONE;
                end else begin
                    n_state = mrpt_pkg::S_SQUARE;
                end
            end
            mrpt_pkg::S_SQUARE: begin
                red_start = 1'b1;
                red_value = r_x * r_x;
                n_state   = mrpt_pkg::S_SQ_RED;
            end
            mrpt_pkg::S_SQ_RED: if (red_ctl.done) n_state = mrpt_pkg::S_SQ_CHECK;
            mrpt_pkg::S_SQ_CHECK: begin
                if (r_x == W'(1)) begin
                    n_state = mrpt_pkg::S_DONE;
                end else if (r_x == nm1) begin
                    n_state = mrpt_pkg::S_TRIAL;
                end else if (r_i + SW'(1) >= r_s) begin
                    n_state = mrpt_pkg::S_DONE;
                end else begin
                    n_state = mrpt_pkg::S_SQUARE;
                end
            end
            mrpt_pkg::S_DONE: n_state = mrpt_pkg::S_IDLE;
            default: n_state = mrpt_pkg::S_IDLE;
        endcase
    end

    assign o_busy           = (r_state != mrpt_pkg::S_IDLE);
    assign o_valid          = r_valid;
    assign o_probably_prime = r_prime;

    `MRPT_ASSERT_IMPL(a_no_start_while_red, i_clk, i_rst_n, red_ctl.busy, !red_start)
    `MRPT_ASSERT_NEXT(a_done_then_valid, i_clk, i_rst_n, r_state == mrpt_pkg::S_DONE, o_valid)
    `MRPT_ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid, r_state == mrpt_pkg::S_IDLE)
endmodule
